// ===== hw/rtl/gsgs_pkg.sv =====
package gsgs_pkg;

  // Default store size
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int RESID_W  = 64;
  localparam int GRID_W   = 7;
  // Wide enough for any row or column count up to the largest store
  localparam int IDX_W    = 11;

  // Stream payload widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = MODE_W;
  localparam int OUT_DATA_W = VAL_W + RESID_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GRID_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWEEP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [RESID_W-1:0]      residual;
    logic signed [VAL_W-1:0] cell_value;
  } res_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_rows;
    logic [GRID_W-1:0] grid_cols;
  } grid_cfg_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ROW   = 7'b0000010,
    ST_ROWD  = 7'b0000100,
    ST_UD    = 7'b0001000,
    ST_CALC  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

// ===== hw/rtl/gsgs_core.sv =====
module gsgs_core #(
  parameter int MAX_ROWS = gsgs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gsgs_pkg::DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gsgs_pkg::grid_cfg_t cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  gsgs_pkg::cmd_t     cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output gsgs_pkg::res_t     res
);
  import gsgs_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;

  // Grid store, two registered read ports and one write port
  logic [VAL_W-1:0] grid_mem [DEPTH];
  logic [VAL_W-1:0] rd_a_r, rd_b_r;
  logic             mem_we, rd_a_en, rd_b_en;
  logic [AW-1:0]    mem_wa, rd_a_addr, rd_b_addr;
  logic [VAL_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    if (rd_a_en) rd_a_r <= grid_mem[rd_a_addr];
    if (rd_b_en) rd_b_r <= grid_mem[rd_b_addr];
  end

  // Control and datapath registers
  state_t               state_r, state_nxt;
  logic [RW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic                 is_read_r, is_read_nxt;
  logic                 inside_r, inside_nxt;
  logic [VAL_W-1:0]     left_r, left_nxt;
  logic [VAL_W-1:0]     center_r, center_nxt;
  logic signed [33:0]   pre_r, pre_nxt;
  logic                 d_v_r, d_v_nxt;
  logic signed [32:0]   diff_r, diff_nxt;
  logic                 m_v_r;
  logic [VAL_W-1:0]     mag_r;
  logic                 s_v_r;
  logic [RESID_W-1:0]   sq_r;
  logic [RESID_W-1:0]   acc_r;
  logic                 acc_clr;

  // Effective grid size, clipped to the store
  logic [IDX_W-1:0] rows_ext, cols_ext, rows_eff, cols_eff, last_row, last_col;
  logic             undersized;

  assign rows_ext   = {{(IDX_W-GRID_W){1'b0}}, cfg.grid_rows};
  assign cols_ext   = {{(IDX_W-GRID_W){1'b0}}, cfg.grid_cols};
  assign rows_eff   = (rows_ext > IDX_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS) : rows_ext;
  assign cols_eff   = (cols_ext > IDX_W'(MAX_COLS)) ? IDX_W'(MAX_COLS) : cols_ext;
  assign last_row   = rows_eff - IDX_W'(2);
  assign last_col   = cols_eff - IDX_W'(2);
  assign undersized = (rows_eff < IDX_W'(3)) || (cols_eff < IDX_W'(3));

  // Address of the item's cell
  logic [IDX_W-1:0] cmd_row_ext, cmd_col_ext;
  logic             cmd_inside;
  logic [AW-1:0]    cmd_addr;

  assign cmd_row_ext = {{(IDX_W-POS_W){1'b0}}, cmd.row};
  assign cmd_col_ext = {{(IDX_W-POS_W){1'b0}}, cmd.col};
  assign cmd_inside  = (cmd_row_ext < IDX_W'(MAX_ROWS)) && (cmd_col_ext < IDX_W'(MAX_COLS));
  assign cmd_addr    = {cmd_row_ext[RW-1:0], cmd_col_ext[CW-1:0]};

  // Cell update arithmetic
  logic signed [33:0]    sum34;
  logic signed [33:0]    quart34;
  logic [VAL_W-1:0]      fresh;
  logic [RW-1:0]         i_up, i_dn;
  logic [CW-1:0]         j_rt;
  logic                  cmd_acc;

  assign sum34   = pre_r + {{2{rd_a_r[VAL_W-1]}}, rd_a_r};
  assign quart34 = sum34 >>> 2;
  assign fresh   = quart34[VAL_W-1:0];
  assign i_up    = i_r - RW'(1);
  assign i_dn    = i_r + RW'(1);
  assign j_rt    = j_r + CW'(1);
  assign cmd_ready = (state_r == ST_IDLE);
  assign cmd_acc   = cmd_valid && cmd_ready;

  // Sequencer: per cell, read up/down, then right, then compute and write back
  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    is_read_nxt = is_read_r;
    inside_nxt  = inside_r;
    left_nxt    = left_r;
    center_nxt  = center_r;
    pre_nxt     = pre_r;
    d_v_nxt     = 1'b0;
    diff_nxt    = diff_r;
    acc_clr     = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = cmd_addr;
    mem_wd      = cmd.value;
    rd_a_en     = 1'b0;
    rd_b_en     = 1'b0;
    rd_a_addr   = cmd_addr;
    rd_b_addr   = cmd_addr;
    case (state_r)
      ST_IDLE: begin
        if (cmd_acc) begin
          case (cmd.mode)
            MODE_WRITE: begin
              mem_we = cmd_inside;
            end
            MODE_READ: begin
              rd_a_en     = cmd_inside;
              inside_nxt  = cmd_inside;
              is_read_nxt = 1'b1;
              state_nxt   = ST_DONE;
            end
            MODE_SWEEP: begin
              acc_clr     = 1'b1;
              is_read_nxt = 1'b0;
              i_nxt       = RW'(1);
              state_nxt   = undersized ? ST_DONE : ST_ROW;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ROW: begin
        rd_a_en   = 1'b1;
        rd_b_en   = 1'b1;
        rd_a_addr = {i_r, CW'(0)};
        rd_b_addr = {i_r, CW'(1)};
        j_nxt     = CW'(1);
        state_nxt = ST_ROWD;
      end
      ST_ROWD: begin
        left_nxt   = rd_a_r;
        center_nxt = rd_b_r;
        rd_a_en    = 1'b1;
        rd_b_en    = 1'b1;
        rd_a_addr  = {i_up, j_r};
        rd_b_addr  = {i_dn, j_r};
        state_nxt  = ST_UD;
      end
      ST_UD: begin
        pre_nxt   = $signed({{2{left_r[VAL_W-1]}}, left_r})
                  + $signed({{2{rd_a_r[VAL_W-1]}}, rd_a_r})
                  + $signed({{2{rd_b_r[VAL_W-1]}}, rd_b_r});
        rd_a_en   = 1'b1;
        rd_a_addr = {i_r, j_rt};
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        // rd_a_r holds the right neighbor
        mem_we     = 1'b1;
        mem_wa     = {i_r, j_r};
        mem_wd     = fresh;
        d_v_nxt    = 1'b1;
        diff_nxt   = $signed({fresh[VAL_W-1], fresh}) - $signed({center_r[VAL_W-1], center_r});
        left_nxt   = fresh;
        center_nxt = rd_a_r;
        if (j_r == last_col[CW-1:0]) begin
          if (i_r == last_row[RW-1:0]) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt     = i_dn;
            state_nxt = ST_ROW;
          end
        end else begin
          j_nxt     = j_rt;
          rd_a_en   = 1'b1;
          rd_b_en   = 1'b1;
          rd_a_addr = {i_up, j_rt};
          rd_b_addr = {i_dn, j_rt};
          state_nxt = ST_UD;
        end
      end
      ST_DRAIN: begin
        if (!d_v_r && !m_v_r && !s_v_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  logic [RESID_W:0] acc_sum;
  assign acc_sum = {1'b0, acc_r} + {1'b0, sq_r};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      d_v_r   <= 1'b0;
      m_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      d_v_r   <= d_v_nxt;
      m_v_r   <= d_v_r;
      s_v_r   <= m_v_r;
      // Accumulate squared change, saturate on carry out
      if (acc_clr) begin
        acc_r <= '0;
      end else if (s_v_r) begin
        acc_r <= acc_sum[RESID_W] ? {RESID_W{1'b1}} : acc_sum[RESID_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    is_read_r <= is_read_nxt;
    inside_r  <= inside_nxt;
    left_r    <= left_nxt;
    center_r  <= center_nxt;
    pre_r     <= pre_nxt;
    diff_r    <= diff_nxt;
    mag_r     <= diff_r[32] ? VAL_W'(-diff_r) : diff_r[VAL_W-1:0];
    sq_r      <= RESID_W'(mag_r) * RESID_W'(mag_r);
  end

  // Result toward the output register
  assign res_valid      = (state_r == ST_DONE);
  assign res.cell_value = (is_read_r && inside_r) ? rd_a_r : '0;
  assign res.residual   = is_read_r ? '0 : acc_r;

  // Write-back never lands on the cell that either port reads
  a_no_rw_collide_a: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && rd_a_en) |-> (mem_wa != rd_a_addr))
    else $error("grid write and port A read hit the same cell");
  a_no_rw_collide_b: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && rd_b_en) |-> (mem_wa != rd_b_addr))
    else $error("grid write and port B read hit the same cell");
  // Sweep write-back stays off the border
  a_interior_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (i_r != '0) && (j_r != '0))
    else $error("sweep wrote a border cell");
  // Residual only grows while squares are added
  a_acc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s_v_r |=> (acc_r >= $past(acc_r)))
    else $error("residual accumulator decreased");
  // A sweep result is offered only after the square pipeline is empty
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !is_read_r) |-> (!d_v_r && !m_v_r && !s_v_r))
    else $error("sweep result offered with squares in flight");

endmodule

// ===== hw/rtl/gauss_seidel_grid_sweep_top.sv =====
// Five-point Gauss-Seidel sweep over a grid of signed Q16.16 cells held in an
// on-chip memory of MAX_ROWS x MAX_COLS words.
// Input stream: in_tuser carries the item kind (write cell, run sweep, read
// cell); in_tdata carries row, column and the value to write. One item is
// worked at a time; in_tready is high while the block is idle, also while an
// earlier result still sits in the output register.
// Output stream: one transaction per read or sweep, none for a write:
// cell_value and residual (sum of squared changes, Q32.32, saturating).
// A write goes straight into the grid memory; a read is registered from the
// memory and then passes to the output register. In a sweep each interior
// cell needs three memory reads (up, down, right) over the two read ports;
// left and center come from registers.
// Configuration: cfg_index 0 sets grid_rows, 1 sets grid_cols; write only
// while idle. cfg_ready is always high.
// Reset (rst_n low, synchronous) idles the block and sets both sizes to 64;
// the grid memory holds no defined data until written.
// A stalled receiver holds out_tvalid and out_tdata; the block finishes the
// current item and then waits with its result until the register frees.
module gauss_seidel_grid_sweep_top #(
  parameter int MAX_ROWS = gsgs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gsgs_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] row, [11:6] col, [43:12] value, [47:44] zero
  input  logic [gsgs_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [gsgs_pkg::IN_USER_W-1:0]  in_tuser,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] cell_value, [95:32] residual
  output logic [gsgs_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsgs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsgs_pkg::*;

  grid_cfg_t cfg_r;
  cmd_t      cmd;
  res_t      res;
  logic      res_valid, res_ready;
  logic      out_valid_r;
  res_t      out_data_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_rows <= GRID_RESET;
      cfg_r.grid_cols <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_ROWS: cfg_r.grid_rows <= cfg_data;
        CFG_GRID_COLS: cfg_r.grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the input transaction
  assign cmd.mode  = in_tuser[MODE_W-1:0];
  assign cmd.row   = in_tdata[POS_W-1:0];
  assign cmd.col   = in_tdata[2*POS_W-1:POS_W];
  assign cmd.value = in_tdata[2*POS_W+VAL_W-1:2*POS_W];

  gsgs_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(in_tvalid),
    .cmd_ready(in_tready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Output register: load when empty or when the receiver takes it
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
